>>> rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the moving-average filter.
// ----------------------------------------------------------------------------
package sma_pkg;

  // Width and reset value of the window length register.
  localparam int unsigned CFG_W = 9;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 9'd8;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_FINISH
  } sma_state_e;

endpackage

>>> rtl/sma_sample_if.sv
// ----------------------------------------------------------------------------
// sma_sample_if
// Valid/ready channel that carries one input sample per item.
// ----------------------------------------------------------------------------
interface sma_sample_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/sma_average_if.sv
// ----------------------------------------------------------------------------
// sma_average_if
// Valid/ready channel that carries one filter average per item.
// ----------------------------------------------------------------------------
interface sma_average_if #(
  parameter int unsigned W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

>>> rtl/moving_average_filter.sv
// Flow: an accepted sample passes through the READ, DIV and FINISH states,
//   with DIV held by the bit-serial divider, and its average is then registered.
// A new sample is taken only once the last one has left FINISH; an average
//   waiting in the output register holds FINISH and so blocks the next sample.
// Reset: the ring is cleared one entry per cycle, and no sample is accepted
//   until the clearing pass is over.
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving-average filter built around a sample ring store, a running
// sum and an iterative divider.
// ----------------------------------------------------------------------------
module moving_average_filter
  import sma_pkg::*;
#(
  parameter int unsigned MAX_WINDOW   = 256,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             window_length_we_i,
  input  logic [CFG_W-1:0] window_length_i,
  sma_sample_if.sink       sample_i,
  sma_average_if.source    average_o
);

  localparam int unsigned POS_W = $clog2(MAX_WINDOW);
  localparam int unsigned LEN_W = $clog2(MAX_WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_WIDTH + POS_W;
  localparam int unsigned EXT_W = SUM_W - SAMPLE_WIDTH;

  localparam logic [SUM_W-1:0] SAT_POS = {{(EXT_W + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic [SUM_W-1:0] SAT_NEG = SAT_POS + 1'b1;

  sma_state_e state_q, state_d;

  logic [CFG_W-1:0]        window_q;
  logic [LEN_W-1:0]        eff_len;
  logic [LEN_W-1:0]        len_q;
  logic [POS_W:0]          pos_inc;
  logic [POS_W-1:0]        pos_next;
  logic [POS_W-1:0]        pos_q;
  logic [POS_W-1:0]        clr_q;
  logic [SAMPLE_WIDTH-1:0] smp_q;
  logic [SUM_W-1:0]        sum_q;
  logic [SUM_W-1:0]        sum_new;
  logic [SUM_W-1:0]        dvd_mag;
  logic                    neg_q;

  logic                    accept;
  logic                    in_ready;
  logic                    mem_we;
  logic [POS_W-1:0]        mem_waddr;
  logic [SAMPLE_WIDTH-1:0] mem_wdata;
  logic [SAMPLE_WIDTH-1:0] mem_rdata;
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [SUM_W-1:0]        div_quo;
  logic                    clr_last;
  logic                    out_load;

  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] average_q;
  logic [SAMPLE_WIDTH-1:0] avg_sat;

  // Window register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (window_length_we_i) begin
      window_q <= window_length_i;
    end
  end

  // A zero window acts as one, an oversized one as the ring depth.
  always_comb begin
    if (window_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(window_q);
    end
  end

  // Next ring slot, wrapping at the window length.
  assign pos_inc  = {1'b0, pos_q} + 1'b1;
  assign pos_next = (32'(pos_inc) >= 32'(eff_len)) ? '0 : pos_inc[POS_W-1:0];

  assign accept   = sample_i.valid && in_ready;
  assign clr_last = (clr_q == POS_W'(MAX_WINDOW - 1));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
      ST_IDLE:   if (sample_i.valid) state_d = ST_READ;
      ST_READ:   state_d = ST_DIV;
      ST_DIV:    if (div_done) state_d = ST_FINISH;
      ST_FINISH: if (!out_valid_q || average_o.ready) state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  // Controller outputs.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos_q;
    mem_wdata = smp_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_IDLE:   in_ready = 1'b1;
      ST_READ: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV:    ;
      ST_FINISH: out_load = !out_valid_q || average_o.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
      len_q   <= LEN_W'(1);
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        pos_q <= pos_next;
        len_q <= eff_len;
      end
      if (state_q == ST_READ) begin
        sum_q <= sum_new;
      end
    end
  end

  // Running sum: drop the old slot content, add the new sample.
  assign sum_new = sum_q
                 - {{EXT_W{mem_rdata[SAMPLE_WIDTH-1]}}, mem_rdata}
                 + {{EXT_W{smp_q[SAMPLE_WIDTH-1]}}, smp_q};
  assign dvd_mag = sum_new[SUM_W-1] ? (~sum_new + 1'b1) : sum_new;

  // Item payload and sign of the sum.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= sample_i.sample;
    end
    if (state_q == ST_READ) begin
      neg_q <= sum_new[SUM_W-1];
    end
  end

  sma_ring #(
    .DEPTH (MAX_WINDOW),
    .WIDTH (SAMPLE_WIDTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (pos_next),
    .rdata_o (mem_rdata)
  );

  sma_div #(
    .DVD_W (SUM_W),
    .DVS_W (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_mag),
    .divisor_i  (len_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Restore the sign and saturate to the sample range.
  always_comb begin
    if (!neg_q && (div_quo > SAT_POS)) begin
      avg_sat = SAT_POS[SAMPLE_WIDTH-1:0];
    end else if (neg_q && (div_quo > SAT_NEG)) begin
      avg_sat = SAT_NEG[SAMPLE_WIDTH-1:0];
    end else if (neg_q) begin
      avg_sat = (~div_quo[SAMPLE_WIDTH-1:0]) + 1'b1;
    end else begin
      avg_sat = div_quo[SAMPLE_WIDTH-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (average_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      average_q <= avg_sat;
    end
  end

  assign sample_i.ready  = in_ready;
  assign average_o.valid = out_valid_q;
  assign average_o.average = average_q;

  // The divider is never restarted while it still works on an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  // A finished item with a free output slot shows up in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !out_valid_q) |=> out_valid_q)
    else $error("finished item not delivered");

  // The divisor of an item in flight lies within the ring depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (len_q != '0 && 32'(len_q) <= 32'(MAX_WINDOW)))
    else $error("divisor out of range");

  // No sample is taken before the clearing pass is over.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !accept || $past(clr_last))
    else $error("sample accepted during ring clear");

endmodule

>>> rtl/sma_ring.sv
// ----------------------------------------------------------------------------
// sma_ring
// Sample ring store: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module sma_ring #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sma_div.sv
// ----------------------------------------------------------------------------
// sma_div
// Restoring divider for unsigned operands, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sma_div #(
  parameter int unsigned DVD_W = 24,
  parameter int unsigned DVS_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  // One trial subtraction per cycle; the dividend shifts out as the
  // quotient shifts in.
  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule
